### rtl/backlight_idle_sleep_fade_top_defines.svh
// Assertion macros shared by the checker of the backlight fader.
// Needs nothing else; include by bare file name.
`ifndef BACKLIGHT_IDLE_SLEEP_FADE_TOP_DEFINES_SVH
`define BACKLIGHT_IDLE_SLEEP_FADE_TOP_DEFINES_SVH
// Implication checked every clock outside reset.
`define BIF_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked every clock outside reset.
`define BIF_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

### rtl/bif_pkg.sv
// Shared types and constants of the backlight idle-sleep fader.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bif_pkg;
   localparam int IdleBits  = 24;
   localparam int AnimBits  = 16;
   localparam int LevelBits = 8;
   localparam int DenBits   = 2 * AnimBits;
   localparam int NumBits   = DenBits + LevelBits + 1;

   localparam logic [2:0] CMD_TICK = 3'd0;
   localparam logic [2:0] CMD_TOGGLE = 3'd2;
   localparam logic [2:0] CMD_UP = 3'd3;
   localparam logic [2:0] CMD_DOWN = 3'd4;

   localparam logic [1:0] MODE_AWAKE = 2'd0;
   localparam logic [1:0] MODE_OUT = 2'd1;
   localparam logic [1:0] MODE_ASLEEP = 2'd2;
   localparam logic [1:0] MODE_IN = 2'd3;

   localparam logic [2:0] REG_IDLE = 3'd0;
   localparam logic [2:0] REG_SLEEP = 3'd1;
   localparam logic [2:0] REG_WAKE = 3'd2;
   localparam logic [2:0] REG_MAX = 3'd3;
   localparam logic [2:0] REG_STEP = 3'd4;
   localparam logic [2:0] REG_CURVE = 3'd5;
   localparam logic [2:0] REG_INIT = 3'd6;

   typedef struct packed {
      logic       load;    // latch the accepted transaction
      logic       mul1;    // form den and num products
      logic       mul2;    // form blend numerator
      logic       div_start;
      logic       commit;  // apply the item to the state
   } ctrl_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
      logic out_pending;
   } stat_type;
endpackage
`default_nettype wire

### rtl/bif_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on bif_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bif_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [bif_pkg::NumBits-1:0]   dividend,
   input  wire logic [bif_pkg::NumBits-1:0]   divisor,
   output logic                               done,
   output logic [bif_pkg::LevelBits-1:0]      quotient
);
   import bif_pkg::*;
   localparam int CntBits = $clog2(NumBits + 1);
   logic [NumBits-1:0] rem_ff, rem_in, quo_ff, quo_in, dsr_ff, dsr_in;
   logic [CntBits-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in, done_ff, done_in;
   logic [NumBits:0]   trial;

   always_comb begin
      rem_in = rem_ff; quo_in = quo_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[NumBits-1]};
      if (start) begin
         rem_in = '0; quo_in = dividend; dsr_in = divisor;
         cnt_in = CntBits'(NumBits); busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NumBits-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = NumBits'(trial - {1'b0, dsr_ff});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[NumBits-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in; quo_ff <= quo_in; dsr_ff <= dsr_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   // quotient never exceeds the largest 8-bit level (255)
   assign quotient = quo_ff[LevelBits-1:0];
endmodule
`default_nettype wire

### rtl/bif_datapath.sv
// State registers, fade arithmetic and result register of the fader.
// Depends on bif_pkg and bif_div.
`timescale 1ns / 1ps
`default_nettype none
module bif_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire bif_pkg::ctrl_type    ctrl,
   output bif_pkg::stat_type         stat,
   input  wire logic [2:0]           in_cmd,
   input  wire logic                 in_pressed,
   input  wire logic                 csr_valid,
   input  wire logic [2:0]           csr_index,
   input  wire logic [23:0]          csr_data,
   input  wire logic                 out_ready,
   output logic                      out_valid,
   output logic [7:0]                out_level,
   output logic                      out_enabled,
   output logic [1:0]                out_mode
);
   import bif_pkg::*;
   logic [IdleBits-1:0]  timeout_ff, idle_ff, idle_in;
   logic [AnimBits-1:0]  sleep_ff, wake_ff, anim_ff, anim_in;
   logic [LevelBits-1:0] maxl_ff, step_ff;
   logic                 curve_ff;
   logic                 on_ff, on_in, pend_ff, pend_in;
   logic [1:0]           mode_ff, mode_in;
   logic [LevelBits-1:0] start_ff, start_in, rem_ff, rem_in, shown_ff, shown_in;
   logic [LevelBits-1:0] last_ff, last_in;
   logic [2:0]           cmd_ff;
   logic                 prs_ff;
   logic [7:0]           rlev_ff, rlev_in;
   logic                 ren_ff, ren_in, rvalid_ff, rvalid_in;
   logic [1:0]           rmode_ff, rmode_in;
   // blend operands
   logic [LevelBits-1:0] s_lv, r_lv;
   logic [AnimBits-1:0]  dur, a_cl;
   logic                 ease;
   logic [DenBits-1:0]   den_ff, num_ff;
   logic [NumBits-1:0]   tot_ff, dvd, dvs;
   logic [AnimBits:0]    twod_m_a;
   logic [LevelBits-1:0] blend_v;
   logic                 div_done;
   logic [IdleBits-1:0]  idle_t;
   logic [AnimBits-1:0]  anim_t;
   logic [LevelBits:0]   up_sum;
   logic [LevelBits-1:0] v, cap;
   logic                 trig;

   function automatic logic [LevelBits-1:0] clampl(input logic [LevelBits-1:0] x,
                                                   input logic [LevelBits-1:0] c);
      return (x > c) ? c : x;
   endfunction

   assign cap = maxl_ff;
   assign trig = pend_ff;
   // a pending wake trigger reloads the fade-in start level before the blend
   assign s_lv = (mode_ff == MODE_OUT) ? rem_ff : (trig ? shown_ff : start_ff);
   assign r_lv = (mode_ff == MODE_OUT) ? '0 : rem_ff;
   assign dur  = (mode_ff == MODE_OUT) ? sleep_ff : wake_ff;
   assign ease = (mode_ff == MODE_OUT) ? 1'b0 : curve_ff;
   assign idle_t = (idle_ff != '1) ? idle_ff + 1'b1 : idle_ff;
   assign anim_t = (anim_ff != '1) ? anim_ff + 1'b1 : anim_ff;
   assign a_cl = (anim_t > dur) ? dur : anim_t;
   assign twod_m_a = {dur, 1'b0} - {1'b0, a_cl};
   assign dvd = {tot_ff[NumBits-2:0], 1'b0} + NumBits'(den_ff);
   assign dvs = {{(NumBits-DenBits-1){1'b0}}, den_ff, 1'b0};

   assign stat.need_div = (cmd_ff == CMD_TICK) && on_ff && (dur != '0) &&
                          ((mode_ff == MODE_OUT && !trig) || mode_ff == MODE_IN);
   assign stat.out_pending = rvalid_ff;
   assign stat.div_done = div_done;

   bif_div u_div (
      .clock(clock), .reset(reset), .start(ctrl.div_start),
      .dividend(dvd), .divisor(dvs),
      .done(div_done), .quotient(blend_v)
   );

   always_comb begin
      idle_in = idle_ff; anim_in = anim_ff; on_in = on_ff; pend_in = pend_ff;
      mode_in = mode_ff; start_in = start_ff; rem_in = rem_ff;
      shown_in = shown_ff; last_in = last_ff;
      rlev_in = rlev_ff; ren_in = ren_ff; rmode_in = rmode_ff;
      rvalid_in = rvalid_ff && !out_ready;
      up_sum = {1'b0, shown_ff} + {1'b0, step_ff};
      v = (dur == '0) ? r_lv : blend_v;
      if (ctrl.commit) begin
         if (cmd_ff == CMD_TICK) begin
            idle_in = idle_t; anim_in = anim_t;
            if (on_ff) begin
               if (trig) begin
                  start_in = shown_ff; idle_in = '0;
               end
               unique case (mode_ff)
                  MODE_ASLEEP: begin
                     if (trig) begin
                        mode_in = MODE_IN; anim_in = '0;
                     end else begin
                        shown_in = '0;
                     end
                  end
                  MODE_AWAKE: begin
                     if (idle_in > timeout_ff) begin
                        mode_in = MODE_OUT; rem_in = shown_ff; anim_in = '0;
                     end
                  end
                  default: begin
                     if (trig && mode_ff == MODE_OUT) begin
                        mode_in = MODE_IN; anim_in = '0;
                     end else begin
                        if (v != last_ff) begin
                           shown_in = clampl(v, cap); last_in = v;
                        end
                        if (v == r_lv) begin
                           shown_in = clampl(r_lv, cap);
                           mode_in = (mode_ff == MODE_OUT) ? MODE_ASLEEP : MODE_AWAKE;
                        end
                     end
                  end
               endcase
               pend_in = 1'b0;
            end
         end else begin
            if (on_ff) pend_in = 1'b1;
            if (prs_ff) begin
               if (cmd_ff == CMD_TOGGLE) on_in = !on_ff;
               else if (cmd_ff == CMD_UP && on_ff)
                  shown_in = (up_sum > {1'b0, cap}) ? cap : up_sum[LevelBits-1:0];
               else if (cmd_ff == CMD_DOWN && on_ff)
                  shown_in = clampl((shown_ff < step_ff) ? '0 : shown_ff - step_ff, cap);
            end
         end
         ren_in = on_in && (shown_in != '0);
         rlev_in = ren_in ? shown_in : '0;
         rmode_in = mode_in;
         if (ren_in != ren_ff || rlev_in != rlev_ff || rmode_in != rmode_ff)
            rvalid_in = 1'b1;
      end
      // writing the initial level also loads it into the shown level
      if (csr_valid && csr_index == REG_INIT)
         shown_in = clampl(csr_data[7:0], maxl_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= in_cmd; prs_ff <= in_pressed;
      end
      if (ctrl.mul1) begin
         den_ff <= DenBits'(dur) * DenBits'(dur);
         num_ff <= ease ? DenBits'(a_cl) * DenBits'(twod_m_a)
                        : DenBits'(a_cl) * DenBits'(a_cl);
      end
      if (ctrl.mul2)
         tot_ff <= NumBits'(s_lv) * NumBits'(den_ff - num_ff) +
                   NumBits'(r_lv) * NumBits'(num_ff);
      if (reset) begin
         timeout_ff <= 24'd60000; sleep_ff <= 16'd1000; wake_ff <= 16'd500;
         maxl_ff <= 8'd15; step_ff <= 8'd1; curve_ff <= 1'b1;
         on_ff <= 1'b1; pend_ff <= 1'b1; mode_ff <= MODE_AWAKE;
         idle_ff <= '0; anim_ff <= '0; start_ff <= '0; rem_ff <= '0;
         shown_ff <= 8'd15; last_ff <= '0;
         rlev_ff <= '0; ren_ff <= 1'b0; rmode_ff <= MODE_AWAKE; rvalid_ff <= 1'b0;
      end else begin
         on_ff <= on_in; pend_ff <= pend_in; mode_ff <= mode_in;
         idle_ff <= idle_in; anim_ff <= anim_in; start_ff <= start_in;
         rem_ff <= rem_in; shown_ff <= shown_in; last_ff <= last_in;
         rlev_ff <= rlev_in; ren_ff <= ren_in; rmode_ff <= rmode_in;
         rvalid_ff <= rvalid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_IDLE:  timeout_ff <= csr_data;
               REG_SLEEP: sleep_ff <= csr_data[15:0];
               REG_WAKE:  wake_ff <= csr_data[15:0];
               REG_MAX:   maxl_ff <= csr_data[7:0];
               REG_STEP:  step_ff <= csr_data[7:0];
               REG_CURVE: curve_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   assign out_valid = rvalid_ff;
   assign out_level = rlev_ff;
   assign out_enabled = ren_ff;
   assign out_mode = rmode_ff;
endmodule
`default_nettype wire

### rtl/bif_ctrl.sv
// Sequencing state machine of the fader.
// Depends on bif_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bif_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bif_pkg::stat_type  stat,
   output bif_pkg::ctrl_type       ctrl
);
   import bif_pkg::*;
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001, ST_DEC = 7'b0000010, ST_MUL1 = 7'b0000100,
      ST_MUL2  = 7'b0001000, ST_START = 7'b0010000, ST_DIV = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;
   state_type state_ff, state_in;

   // hold new items until the previous result left
   assign in_ready = (state_ff == ST_IDLE) && !stat.out_pending;

   always_comb begin
      state_in = state_ff;
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: if (in_valid && in_ready) begin
            ctrl.load = 1'b1; state_in = ST_DEC;
         end
         ST_DEC: state_in = stat.need_div ? ST_MUL1 : ST_DONE;
         ST_MUL1: begin
            ctrl.mul1 = 1'b1; state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctrl.mul2 = 1'b1; state_in = ST_START;
         end
         // launch the divider once the numerator register holds its value
         ST_START: begin
            ctrl.div_start = 1'b1; state_in = ST_DIV;
         end
         ST_DIV: if (stat.div_done) state_in = ST_DONE;
         ST_DONE: begin
            ctrl.commit = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

### rtl/backlight_idle_sleep_fade_top.sv
// Channel  | Dir | Payload
// req      | in  | tdata: cmd[2:0], pressed[3]
// rsp      | out | tdata: level[7:0], enabled[8], mode[10:9]
// csr      | in  | index[2:0], data[23:0]
// A key or plain tick passes through decode and commit; a fading tick adds
// the MUL1, MUL2 and START states and the 41-step serial divider (one
// quotient bit a cycle). Reset is synchronous, active high.
// A waiting result holds req_tready low until rsp takes it.
`timescale 1ns / 1ps
`default_nettype none
module backlight_idle_sleep_fade_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // cmd, pressed
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // level, enabled, mode
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);
   import bif_pkg::*;
   ctrl_type ctrl;
   stat_type stat;
   logic [7:0] lv;
   logic       en;
   logic [1:0] md;

   assign csr_ready = 1'b1;

   bif_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_tvalid),
      .in_ready(req_tready), .stat(stat), .ctrl(ctrl)
   );

   bif_datapath u_dp (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .in_cmd(req_tdata[2:0]), .in_pressed(req_tdata[3]),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .out_ready(rsp_tready), .out_valid(rsp_tvalid),
      .out_level(lv), .out_enabled(en), .out_mode(md)
   );

   assign rsp_tdata = {5'd0, md, en, lv};
endmodule
`default_nettype wire

### rtl/bif_checker.sv
// Port-level checks of the backlight fader, bound to the top level.
// Depends on backlight_idle_sleep_fade_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "backlight_idle_sleep_fade_top_defines.svh"
module bif_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);
   `BIF_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `BIF_ASSERT_IMP(a_no_take_while_out, clock, reset, rsp_tvalid, !req_tready)
   `BIF_ASSERT_IMP(a_en_level, clock, reset, rsp_tvalid, rsp_tdata[8] == (rsp_tdata[7:0] != 8'd0))
   `BIF_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
endmodule

bind backlight_idle_sleep_fade_top bif_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire

### tb/tb_backlight_idle_sleep_fade_top.sv
// Self-checking bench for the backlight idle-sleep fader: drives ticks and key
// events, predicts level/enabled/mode changes in-line and compares each response.
// Depends on bif_pkg and backlight_idle_sleep_fade_top.
`timescale 1ns / 1ps
module tb_backlight_idle_sleep_fade_top;
   import bif_pkg::*;

   localparam logic [2:0] CMD_KEY = 3'd1;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [2:0] cmd;
      logic       pressed;
   } press_t;

   typedef struct packed {
      logic [7:0] level;
      logic       enabled;
      logic [1:0] mode;
   } light_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   backlight_idle_sleep_fade_top DUT (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   always #2 clock = ~clock;

   // predictor state and register shadow
   logic [23:0] idle_timeout, idle_cnt;
   logic [15:0] sleep_ms, wake_ms, anim_cnt;
   logic [7:0]  max_lvl, step_lvl, init_lvl;
   logic        curve, light_on, wake_arm;
   logic [1:0]  fmode;
   logic [7:0]  start_lvl, saved_lvl, shown_lvl, last_lvl;
   light_t      last_report;

   press_t pending_items[$];
   light_t expected_lights[$];
   press_t tx_item, rx_item;
   int     errors = 0;
   int     accepted = 0;
   int     responses = 0;
   bit     rx_idle_on = 1'b1;
   bit     tx_idle_on = 1'b1;
   bit     hold_rsp = 1'b0;
   int     hold_count = 0;
   int     quiet_cycles = 0;
   int     mode_seen[4] = '{0, 0, 0, 0};

   function automatic logic [7:0] clamp_level(int unsigned v);
      return (v > max_lvl) ? max_lvl : v[7:0];
   endfunction

   function automatic logic [7:0] fade_value(logic [7:0] s, logic [7:0] r,
                                             logic [15:0] a, logic [15:0] d,
                                             logic ease_out);
      logic [63:0] den, num, total, aa;
      if (d == 0) begin
         den = 1;
         num = 1;
      end else begin
         aa = (a > d) ? d : a;
         den = 64'(d) * 64'(d);
         num = ease_out ? aa * (2 * 64'(d) - aa) : aa * aa;
      end
      total = 64'(s) * (den - num) + 64'(r) * num;
      return 8'((2 * total + den) / (2 * den));
   endfunction

   task automatic fade_step(logic [7:0] v, logic [7:0] target, logic [1:0] next_mode);
      if (v != last_lvl) begin
         shown_lvl = clamp_level(v);
         last_lvl = v;
      end
      if (v == target) begin
         shown_lvl = clamp_level(target);
         fmode = next_mode;
      end
   endtask

   task automatic advance_light(press_t it);
      logic   trig;
      light_t now;
      if (it.cmd == CMD_TICK) begin
         trig = wake_arm;
         if (idle_cnt != 24'hFFFFFF) idle_cnt++;
         if (anim_cnt != 16'hFFFF) anim_cnt++;
         if (light_on) begin
            if (trig) begin
               start_lvl = shown_lvl;
               idle_cnt = 0;
            end
            case (fmode)
               MODE_ASLEEP: begin
                  if (trig) begin
                     fmode = MODE_IN;
                     anim_cnt = 0;
                  end else if (shown_lvl > 0) begin
                     shown_lvl = 0;
                  end
               end
               MODE_OUT: begin
                  if (trig) begin
                     fmode = MODE_IN;
                     anim_cnt = 0;
                  end else begin
                     fade_step(fade_value(saved_lvl, 0, anim_cnt, sleep_ms, 1'b0), 0,
                               MODE_ASLEEP);
                  end
               end
               MODE_AWAKE: begin
                  if (idle_cnt > idle_timeout) begin
                     fmode = MODE_OUT;
                     saved_lvl = shown_lvl;
                     anim_cnt = 0;
                  end
               end
               default: fade_step(fade_value(start_lvl, saved_lvl, anim_cnt, wake_ms, curve),
                                  saved_lvl, MODE_AWAKE);
            endcase
            wake_arm = 1'b0;
         end
      end else begin
         if (light_on) wake_arm = 1'b1;
         if (it.pressed) begin
            if (it.cmd == CMD_TOGGLE) light_on = ~light_on;
            else if (it.cmd == CMD_UP && light_on)
               shown_lvl = clamp_level(int'(shown_lvl) + int'(step_lvl));
            else if (it.cmd == CMD_DOWN && light_on)
               shown_lvl = clamp_level((shown_lvl < step_lvl) ? 0 : shown_lvl - step_lvl);
         end
      end
      now.enabled = light_on && shown_lvl != 0;
      now.level = now.enabled ? shown_lvl : 8'd0;
      now.mode = fmode;
      if (now != last_report) begin
         last_report = now;
         expected_lights.push_back(now);
      end
   endtask

   task automatic shadow_write(logic [2:0] idx, logic [23:0] val);
      case (idx)
         REG_IDLE:  idle_timeout = val;
         REG_SLEEP: sleep_ms = val[15:0];
         REG_WAKE:  wake_ms = val[15:0];
         REG_MAX:   max_lvl = val[7:0];
         REG_STEP:  step_lvl = val[7:0];
         REG_CURVE: curve = val[0];
         REG_INIT: begin
            init_lvl = val[7:0];
            shown_lvl = clamp_level(init_lvl);
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            rx_item.cmd = req_tdata[2:0];
            rx_item.pressed = req_tdata[3];
            advance_light(rx_item);
            accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (pending_items.size() > 0 &&
                (!tx_idle_on || $urandom_range(99) >= 32)) begin
               tx_item = pending_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'd0, tx_item.pressed, tx_item.cmd};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor and response checker
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            light_t got, want;
            got.level = rsp_tdata[7:0];
            got.enabled = rsp_tdata[8];
            got.mode = rsp_tdata[10:9];
            responses++;
            if (expected_lights.size() == 0) begin
               $error("unexpected transaction level=%0d enabled=%0d mode=%0d",
                      got.level, got.enabled, got.mode);
               errors++;
            end else begin
               want = expected_lights.pop_front();
               mode_seen[got.mode]++;
               if (got.level !== want.level) begin
                  $error("level expected %0d actual %0d", want.level, got.level);
                  errors++;
               end
               if (got.enabled !== want.enabled) begin
                  $error("enabled expected %0d actual %0d", want.enabled, got.enabled);
                  errors++;
               end
               if (got.mode !== want.mode) begin
                  $error("mode expected %0d actual %0d", want.mode, got.mode);
                  errors++;
               end
            end
         end
         if (hold_rsp) begin
            hold_count++;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !rx_idle_on || $urandom_range(99) >= 32;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      while (pending_items.size() > 0 || req_tvalid || expected_lights.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(logic [2:0] idx, logic [23:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_write(idx, val);
   endtask

   task automatic queue_item(logic [2:0] cmd, logic pressed);
      press_t it;
      it.cmd = cmd;
      it.pressed = pressed;
      pending_items.push_back(it);
   endtask

   task automatic queue_ticks(int n);
      repeat (n) queue_item(CMD_TICK, 1'($urandom_range(1)));
   endtask

   // random phase: idle/fade episodes with random keys and tick bursts
   task automatic queue_random(int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: queue_item(CMD_TICK, 1'($urandom_range(1)));
            5: queue_item(CMD_UP, 1'($urandom_range(1)));
            6: queue_item(CMD_DOWN, 1'($urandom_range(1)));
            7: queue_item($urandom_range(99) < 70 ? CMD_KEY : 3'($urandom_range(5, 7)),
                          1'($urandom_range(1)));
            8: queue_item(CMD_TOGGLE, $urandom_range(99) < 30);
            default: begin
               queue_ticks($urandom_range(5, 30));
               k += 10;
            end
         endcase
      end
   endtask

   task automatic configure(logic [23:0] idle, logic [15:0] sl, logic [15:0] wk,
                            logic [7:0] mx, logic [7:0] st, logic cv, logic [7:0] il);
      write_reg(REG_IDLE, idle);
      write_reg(REG_SLEEP, {8'd0, sl});
      write_reg(REG_WAKE, {8'd0, wk});
      write_reg(REG_MAX, {16'd0, mx});
      write_reg(REG_STEP, {16'd0, st});
      write_reg(REG_CURVE, {23'd0, cv});
      write_reg(REG_INIT, {16'd0, il});
      csr_valid <= 1'b0;
   endtask

   initial begin
      int ph;
      idle_timeout = 60000; sleep_ms = 1000; wake_ms = 500; max_lvl = 15;
      step_lvl = 1; curve = 1'b1; init_lvl = 15;
      light_on = 1'b1; fmode = MODE_AWAKE; wake_arm = 1'b1;
      idle_cnt = 0; anim_cnt = 0; start_lvl = 0; saved_lvl = 0; last_lvl = 0;
      shown_lvl = 15; last_report = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every command, both press states, saturation at both ends
      configure(24'd3, 16'd4, 16'd3, 8'd255, 8'd255, 1'b0, 8'd255);
      queue_item(CMD_TICK, 1'b1);
      queue_item(CMD_UP, 1'b1);
      queue_item(CMD_DOWN, 1'b1);
      queue_item(CMD_DOWN, 1'b1);
      queue_item(CMD_UP, 1'b0);
      queue_item(CMD_KEY, 1'b1);
      queue_item(3'd7, 1'b1);
      queue_item(CMD_TOGGLE, 1'b1);
      queue_item(CMD_UP, 1'b1);
      queue_ticks(3);
      queue_item(CMD_TOGGLE, 1'b0);
      queue_item(CMD_TOGGLE, 1'b1);
      queue_item(CMD_UP, 1'b1);
      queue_ticks(12);
      wait_drained();

      // sender pause above; now hold the receiver long to back up the block
      tx_idle_on = 1'b0;
      hold_rsp = 1'b1;
      queue_random(40);
      while (hold_count < 400) @(posedge clock);
      hold_rsp = 1'b0;
      tx_idle_on = 1'b1;
      wait_drained();

      // zero max_level, zero timeout, shortest and longest fades
      configure(24'd0, 16'd1, 16'd65535, 8'd0, 8'd1, 1'b1, 8'd0);
      queue_random(60);
      wait_drained();
      for (ph = 0; ph < 6; ph++) begin
         configure(24'($urandom_range(0, 40)), 16'($urandom_range(1, 30)),
                   16'($urandom_range(1, 30)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 1'($urandom_range(1)),
                   8'($urandom_range(0, 255)));
         rx_idle_on = (ph != 3);
         tx_idle_on = (ph != 3);
         queue_random(130);
         wait_drained();
      end
      configure(24'hFFFFFF, 16'd65535, 16'd1, 8'd255, 8'd1, 1'b0, 8'd128);
      queue_random(40);
      wait_drained();

      $display("Covered %0d input transactions, %0d responses; modes seen %0d/%0d/%0d/%0d",
               accepted, responses, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
      if (errors == 0 && expected_lights.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

### backlight_idle_sleep_fade_top.f
+incdir+rtl
rtl/bif_pkg.sv
rtl/bif_div.sv
rtl/bif_datapath.sv
rtl/bif_ctrl.sv
rtl/backlight_idle_sleep_fade_top.sv
rtl/bif_checker.sv
tb/tb_backlight_idle_sleep_fade_top.sv
